>>> rtl/fvcc_pkg.sv
// Shared types and constant tables for the flow vector colour coder.
// No dependencies; imported by fvcc_front, fvcc_back, the top level and the bench.
`timescale 1ns / 1ps

package fvcc_pkg;

  typedef enum logic [1:0] {
    OP_MEASURE,
    OP_SKIP,
    OP_COLOR,
    OP_BLACK
  } fvcc_op_e;

  typedef struct packed {
    fvcc_op_e op;
    logic     frame_start;
  } fvcc_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_U,
    ST_SQ_V,
    ST_SETUP,
    ST_ROOT,
    ST_DIV,
    ST_ANGLE_INIT,
    ST_ANGLE,
    ST_COLOR_C,
    ST_COLOR_B,
    ST_OUT
  } fvcc_state_e;

  localparam int unsigned WheelSize = 55;
  localparam int unsigned CordicSteps = 24;
  localparam logic [15:0] UnitRadius = 16'd64;
  localparam logic [23:0] FullScale = 24'd16711680;  // 255 * 2^16

  // Colour wheel, packed as red, green, blue.
  localparam logic [23:0] WHEEL [WheelSize] = '{
    24'hFF0000, 24'hFF1100, 24'hFF2200, 24'hFF3300, 24'hFF4400, 24'hFF5500,
    24'hFF6600, 24'hFF7700, 24'hFF8800, 24'hFF9900, 24'hFFAA00, 24'hFFBB00,
    24'hFFCC00, 24'hFFDD00, 24'hFFEE00,
    24'hFFFF00, 24'hD5FF00, 24'hAAFF00, 24'h80FF00, 24'h55FF00, 24'h2BFF00,
    24'h00FF00, 24'h00FF3F, 24'h00FF7F, 24'h00FFBF,
    24'h00FFFF, 24'h00E8FF, 24'h00D1FF, 24'h00BAFF, 24'h00A3FF, 24'h008CFF,
    24'h0074FF, 24'h005DFF, 24'h0046FF, 24'h002FFF, 24'h0018FF,
    24'h0000FF, 24'h1300FF, 24'h2700FF, 24'h3A00FF, 24'h4E00FF, 24'h6200FF,
    24'h7500FF, 24'h8900FF, 24'h9C00FF, 24'hB000FF, 24'hC400FF, 24'hD700FF,
    24'hEB00FF,
    24'hFF00FF, 24'hFF00D5, 24'hFF00AA, 24'hFF0080, 24'hFF0055, 24'hFF002B
  };

  // Arctangent of 2^-i in units of 2^-32 of a turn.
  localparam logic [31:0] ATAN [CordicSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
    32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
    32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic logic [7:0] wheel_byte(input logic [5:0] k, input logic [1:0] ch);
    logic [23:0] e;
    e = (k < 6'(WheelSize)) ? WHEEL[k] : 24'h000000;
    case (ch)
      2'd0:    wheel_byte = e[23:16];
      2'd1:    wheel_byte = e[15:8];
      default: wheel_byte = e[7:0];
    endcase
  endfunction

endpackage

>>> rtl/fvcc_front.sv
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on fvcc_pkg.
`timescale 1ns / 1ps

module fvcc_front #(
  parameter int unsigned FLOW_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic                   frame_start_i,
  input  logic [FLOW_WIDTH-1:0]  flow_u_i,
  input  logic [FLOW_WIDTH-1:0]  flow_v_i,
  input  logic                   is_unknown_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output fvcc_pkg::fvcc_cmd_t    q_cmd_o,
  output logic [FLOW_WIDTH-1:0]  q_u_o,
  output logic [FLOW_WIDTH-1:0]  q_v_o
);
  import fvcc_pkg::*;

  fvcc_cmd_t             cmd_q [2];
  logic [FLOW_WIDTH-1:0] u_q [2];
  logic [FLOW_WIDTH-1:0] v_q [2];
  logic                  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]            count_q, count_d;
  logic                  push, pop;
  fvcc_cmd_t             cmd_in;

  always_comb begin
    case ({func_i, is_unknown_i})
      2'b00:   cmd_in.op = OP_MEASURE;
      2'b01:   cmd_in.op = OP_SKIP;
      2'b10:   cmd_in.op = OP_COLOR;
      default: cmd_in.op = OP_BLACK;
    endcase
    cmd_in.frame_start = frame_start_i;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_cmd_o    = cmd_q[rd_ptr_q];
  assign q_u_o      = u_q[rd_ptr_q];
  assign q_v_o      = v_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q] <= cmd_in;
      u_q[wr_ptr_q]   <= flow_u_i;
      v_q[wr_ptr_q]   <= flow_v_i;
    end
  end

endmodule

>>> rtl/fvcc_back.sv
// Back end: sequencer with shared square, square-root, divide, CORDIC and blend units.
// Depends on fvcc_pkg; fed by fvcc_front.
`timescale 1ns / 1ps

module fvcc_back #(
  parameter int unsigned FLOW_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [15:0]            max_motion_i,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  fvcc_pkg::fvcc_cmd_t    q_cmd_i,
  input  logic [FLOW_WIDTH-1:0]  q_u_i,
  input  logic [FLOW_WIDTH-1:0]  q_v_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o
);
  import fvcc_pkg::*;

  localparam int unsigned W  = FLOW_WIDTH;
  localparam int unsigned XW = FLOW_WIDTH + 19;

  fvcc_state_e state_q, state_d;
  fvcc_op_e    op_q, op_d;
  logic [W-1:0]        u_q, u_d, v_q, v_d, au_q, au_d, av_q, av_d;
  logic [2*W-1:0]      sq_q, sq_d, s_q, s_d;
  logic [15:0]         d_q, d_d, run_max_q, run_max_d, drem_q, drem_d;
  logic                inside_q, inside_d, skip_q, skip_d;
  logic [63:0]         op64_q, op64_d;
  logic [33:0]         rem_q, rem_d;
  logic [31:0]         root_q, root_d, ang_q, ang_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [16:0]         r_q, r_d;
  logic signed [XW-1:0] x_q, x_d, y_q, y_d;
  logic [1:0]          ch_q, ch_d;
  logic [23:0]         c_q, c_d;
  logic [7:0]          rgb_q [3];
  logic [7:0]          rgb_d [3];
  logic                out_valid_q, out_valid_d;
  logic [7:0]          red_q, red_d, green_q, green_d, blue_q, blue_d;

  logic [W-1:0]        mul_a, abs_u_in, abs_v_in;
  logic [2*W-1:0]      mul_p;
  logic [31:0]         dd;
  logic [33:0]         rem_sh, trial;
  logic [16:0]         div_t;
  logic signed [XW-1:0] xs, ys, x_init;
  logic                y_pos;
  logic [21:0]         fk;
  logic [5:0]          k0, k1;
  logic [15:0]         frac;
  logic [7:0]          w0, w1;
  logic [24:0]         c_next;
  logic [40:0]         prod, diff;
  logic [25:0]         tri_c;
  logic [7:0]          byte_val;

  assign abs_u_in = q_u_i[W-1] ? (~q_u_i + W'(1)) : q_u_i;
  assign abs_v_in = q_v_i[W-1] ? (~q_v_i + W'(1)) : q_v_i;
  assign mul_a    = (state_q == ST_SQ_U) ? au_q : av_q;
  assign mul_p    = (2*W)'(mul_a) * (2*W)'(mul_a);
  assign dd       = 32'(d_q) * 32'(d_q);

  // One result bit of the square root per cycle, two operand bits consumed.
  assign rem_sh = {rem_q[31:0], op64_q[63:62]};
  assign trial  = {root_q, 2'b01};
  // Restoring division of the root by the radius, one quotient bit per cycle.
  assign div_t  = {drem_q, root_q[31]};

  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign y_pos  = !y_q[XW-1] && (y_q != '0);
  assign x_init = {{3{u_q[W-1]}}, u_q, 16'b0};

  assign fk       = 22'(ang_q[31:16]) * 22'd54;
  assign k0       = fk[21:16];
  assign k1       = (k0 == 6'(WheelSize - 1)) ? 6'd0 : k0 + 6'd1;
  assign frac     = fk[15:0];
  assign w0       = wheel_byte(k0, ch_q);
  assign w1       = wheel_byte(k1, ch_q);
  assign c_next   = 25'(w0) * (25'h10000 - 25'(frac)) + 25'(w1) * 25'(frac);
  assign prod     = 41'(r_q) * 41'(FullScale - c_q);
  assign diff     = {1'b0, FullScale, 16'b0} - prod;
  assign tri_c    = 26'(c_q) * 26'd3;
  assign byte_val = inside_q ? diff[39:32] : tri_c[25:18];

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    u_d         = u_q;
    v_d         = v_q;
    au_d        = au_q;
    av_d        = av_q;
    sq_d        = sq_q;
    s_d         = s_q;
    d_d         = d_q;
    run_max_d   = run_max_q;
    drem_d      = drem_q;
    inside_d    = inside_q;
    skip_d      = skip_q;
    op64_d      = op64_q;
    rem_d       = rem_q;
    root_d      = root_q;
    ang_d       = ang_q;
    cnt_d       = cnt_q;
    r_d         = r_q;
    x_d         = x_q;
    y_d         = y_q;
    ch_d        = ch_q;
    c_d         = c_q;
    rgb_d       = rgb_q;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_ready_o   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          op_d = q_cmd_i.op;
          u_d  = q_u_i;
          v_d  = q_v_i;
          au_d = abs_u_in;
          av_d = abs_v_in;
          case (q_cmd_i.op)
            OP_MEASURE: begin
              if (q_cmd_i.frame_start) run_max_d = '0;
              state_d = ST_SQ_U;
            end
            OP_SKIP: begin
              if (q_cmd_i.frame_start) run_max_d = '0;
            end
            OP_COLOR: state_d = ST_SQ_U;
            default: begin
              rgb_d   = '{8'd0, 8'd0, 8'd0};
              state_d = ST_OUT;
            end
          endcase
        end
      end
      ST_SQ_U: begin
        sq_d = mul_p;
        if (max_motion_i != '0) d_d = max_motion_i;
        else if (run_max_q != '0) d_d = run_max_q;
        else d_d = UnitRadius;
        state_d = ST_SQ_V;
      end
      ST_SQ_V: begin
        s_d     = sq_q + mul_p;
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        inside_d = (64'(s_q) <= 64'(dd));
        rem_d    = '0;
        root_d   = '0;
        cnt_d    = '0;
        if (op_q == OP_MEASURE) begin
          op64_d  = 64'(s_q);
          state_d = ST_ROOT;
        end else if (64'(s_q) <= 64'(dd)) begin
          op64_d  = 64'(s_q) << 32;
          state_d = ST_ROOT;
        end else begin
          r_d     = '0;
          state_d = ST_ANGLE_INIT;
        end
      end
      ST_ROOT: begin
        op64_d = {op64_q[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[30:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          cnt_d  = '0;
          drem_d = '0;
          if (op_q == OP_MEASURE) begin
            if (root_d[31:16] != '0) begin
              if (run_max_q != 16'hFFFF) run_max_d = 16'hFFFF;
            end else if (root_d[15:0] > run_max_q) begin
              run_max_d = root_d[15:0];
            end
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_t >= {1'b0, d_q}) begin
          drem_d = 16'(div_t - {1'b0, d_q});
          root_d = {root_q[30:0], 1'b1};
        end else begin
          drem_d = div_t[15:0];
          root_d = {root_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          r_d     = (root_d > 32'h10000) ? 17'h10000 : root_d[16:0];
          state_d = ST_ANGLE_INIT;
        end
      end
      ST_ANGLE_INIT: begin
        cnt_d  = '0;
        skip_d = (v_q == '0);
        if (u_q[W-1]) begin
          x_d   = -x_init;
          y_d   = -({{3{v_q[W-1]}}, v_q, 16'b0});
          ang_d = 32'h8000_0000;
        end else begin
          x_d   = x_init;
          y_d   = {{3{v_q[W-1]}}, v_q, 16'b0};
          ang_d = '0;
        end
        state_d = ST_ANGLE;
      end
      ST_ANGLE: begin
        if (!skip_q) begin
          if (y_pos) begin
            x_d   = x_q + ys;
            y_d   = y_q - xs;
            ang_d = ang_q + ATAN[cnt_q];
          end else begin
            x_d   = x_q - ys;
            y_d   = y_q + xs;
            ang_d = ang_q - ATAN[cnt_q];
          end
        end
        cnt_d = cnt_q + 5'd1;
        if (skip_q || cnt_q == 5'(CordicSteps - 1)) begin
          ch_d    = '0;
          state_d = ST_COLOR_C;
        end
      end
      ST_COLOR_C: begin
        c_d     = c_next[23:0];
        state_d = ST_COLOR_B;
      end
      ST_COLOR_B: begin
        rgb_d[ch_q] = byte_val;
        if (ch_q == 2'd2) begin
          state_d = ST_OUT;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = ST_COLOR_C;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          red_d       = rgb_q[0];
          green_d     = rgb_q[1];
          blue_d      = rgb_q[2];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_max_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_max_q   <= run_max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    u_q      <= u_d;
    v_q      <= v_d;
    au_q     <= au_d;
    av_q     <= av_d;
    sq_q     <= sq_d;
    s_q      <= s_d;
    d_q      <= d_d;
    drem_q   <= drem_d;
    inside_q <= inside_d;
    skip_q   <= skip_d;
    op64_q   <= op64_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    ang_q    <= ang_d;
    cnt_q    <= cnt_d;
    r_q      <= r_d;
    x_q      <= x_d;
    y_q      <= y_d;
    ch_q     <= ch_d;
    c_q      <= c_d;
    rgb_q    <= rgb_d;
    red_q    <= red_d;
    green_q  <= green_d;
    blue_q   <= blue_d;
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

>>> rtl/flow_vector_color_coder_unit.sv
// Top level of the flow vector colour coder: configuration register, front end and back end.
// Depends on fvcc_pkg, fvcc_front and fvcc_back.
`timescale 1ns / 1ps

// Codes flow vectors as colours on the 55-entry wheel. A request with func_i low is a
// measure request and updates the running maximum length; one with func_i high yields one
// RGB pixel. Requests enter a two-entry queue and are worked one at a time by a sequencer
// whose shared square-root unit, divider and CORDIC unit each iterate one step per cycle.
// A measure request runs the 32 root steps; an unknown one runs none. A colour request
// inside the radius runs 32 root steps, 32 divide steps, 24 CORDIC steps and the blend of
// each channel; one outside the radius skips the root and divide steps. Both skip the
// CORDIC steps when the vertical component is zero, and an unknown vector is output as
// black. A stalled output holds the back end. The normalising radius is written through
// cfg_we_i and cfg_wdata_i; the user must write it only while the block is idle, since
// the block itself does not enforce this.
module flow_vector_color_coder_unit #(
  parameter int unsigned FLOW_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic                  frame_start_i,
  input  logic [FLOW_WIDTH-1:0] flow_u_i,
  input  logic [FLOW_WIDTH-1:0] flow_v_i,
  input  logic                  is_unknown_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o
);
  import fvcc_pkg::*;

  logic [15:0]           max_motion_q;
  logic                  q_valid, q_ready;
  fvcc_cmd_t             q_cmd;
  logic [FLOW_WIDTH-1:0] q_u, q_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_motion_q <= '0;
    end else if (cfg_we_i) begin
      max_motion_q <= cfg_wdata_i;
    end
  end

  fvcc_front #(.FLOW_WIDTH(FLOW_WIDTH)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .frame_start_i (frame_start_i),
    .flow_u_i      (flow_u_i),
    .flow_v_i      (flow_v_i),
    .is_unknown_i  (is_unknown_i),
    .q_valid_o     (q_valid),
    .q_ready_i     (q_ready),
    .q_cmd_o       (q_cmd),
    .q_u_o         (q_u),
    .q_v_o         (q_v)
  );

  fvcc_back #(.FLOW_WIDTH(FLOW_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_motion_i (max_motion_q),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_cmd_i      (q_cmd),
    .q_u_i        (q_u),
    .q_v_i        (q_v),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

endmodule

>>> rtl/fvcc_checker.sv
// Port-level checks for the flow vector colour coder, bound to the top level.
// Depends on flow_vector_color_coder_unit.
`timescale 1ns / 1ps

module fvcc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o
);

  // A pixel that is stalled stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) && $stable(green_o)
      && $stable(blue_o))
    else $error("stalled pixel changed");

  // The queue can only fill up through an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i) && $past(in_ready_o))
    else $error("ready fell without a request");

  // Leaving reset, nothing is offered and the queue is open.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && in_ready_o)
    else $error("bad state after reset");

endmodule

bind flow_vector_color_coder_unit fvcc_checker u_fvcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o)
);

>>> bench/flow_vector_color_coder_unit_tb.sv
// Self-checking bench for flow_vector_color_coder_unit: directed table, then random frames.
// Depends on fvcc_pkg and the RTL of the block; holds its own colour-coding predictor.
`timescale 1ns / 1ps

module flow_vector_color_coder_unit_tb;
  import fvcc_pkg::*;

  typedef struct {
    bit          func;
    bit          fs;
    logic [15:0] u;
    logic [15:0] v;
    bit          unk;
    bit          typed;
    logic [23:0] rgb;
  } pixel_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_func = 1'b0, req_fs = 1'b0, req_unk = 1'b0;
  logic [15:0] req_u = '0, req_v = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  red, green, blue;

  flow_vector_color_coder_unit #(.FLOW_WIDTH(16)) uut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(req_func), .frame_start_i(req_fs),
    .flow_u_i(req_u), .flow_v_i(req_v), .is_unknown_i(req_unk),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .red_o(red), .green_o(green), .blue_o(blue)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state.
  int unsigned colour_tab [WheelSize][3];
  logic [15:0] norm_radius = '0;
  logic [15:0] peak_len = '0;
  logic [23:0] pixel_q [$];
  int          mismatches = 0;
  int          burst_left = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] direction_of(input longint u, input longint v);
    longint x, y, xs, ys;
    logic [31:0] ang;
    x = u * 65536;
    y = v * 65536;
    ang = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    if (y != 0) begin
      for (int i = 0; i < CordicSteps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; ang += ATAN[i];
        end else begin
          x -= ys; y += xs; ang -= ATAN[i];
        end
      end
    end
    return ang[31:16];
  endfunction

  // Works out the pixel for one colour request; measure requests update peak_len only.
  function automatic logic [23:0] code_pixel(input pixel_req_t q);
    longint u, v;
    longint unsigned s, d, fk, f, r, c, full, bytev;
    int unsigned k0, k1;
    logic [23:0] px;
    u = longint'($signed(q.u));
    v = longint'($signed(q.v));
    s = u * u + v * v;
    px = '0;
    if (!q.func) begin
      if (q.fs) peak_len = '0;
      if (!q.unk && int_sqrt(s) > peak_len) peak_len = 16'(int_sqrt(s));
    end else if (!q.unk) begin
      d = norm_radius != 0 ? norm_radius : (peak_len != 0 ? peak_len : 64);
      fk = direction_of(u, v) * 54;
      k0 = 32'(fk >> 16);
      k1 = (k0 + 1) % WheelSize;
      f = fk & 16'hFFFF;
      full = 255 * 65536;
      r = 0;
      if (s <= d * d) begin
        r = int_sqrt(s << 32) / d;
        if (r > 65536) r = 65536;
      end
      for (int ch = 0; ch < 3; ch++) begin
        c = colour_tab[k0][ch] * (65536 - f) + colour_tab[k1][ch] * f;
        if (s <= d * d) bytev = ((full << 16) - r * (full - c)) >> 32;
        else bytev = (3 * c) >> 18;
        px[23 - 8 * ch -: 8] = bytev[7:0];
      end
    end
    return px;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  task automatic send_req(input pixel_req_t q);
    logic [23:0] px;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_func <= q.func; req_fs <= q.fs; req_u <= q.u; req_v <= q.v; req_unk <= q.unk;
    do @(posedge clk_i); while (!in_ready);
    px = code_pixel(q);
    if (q.func) pixel_q.push_back(q.typed ? q.rgb : px);
  endtask

  // Holds off until every pixel has come out and the block has drained.
  task automatic drain;
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    norm_radius = val;
  endtask

  function automatic logic [15:0] rand_comp();
    logic [15:0] m;
    case ($urandom_range(0, 5))
      0: m = 16'($urandom);
      1: m = 16'h8000 | 16'($urandom_range(0, 3));
      2: m = 16'($urandom_range(0, 3));
      3: m = 16'hFFFF - 16'($urandom_range(0, 300));
      default: m = 16'($urandom_range(0, 1500));
    endcase
    return m;
  endfunction

  function automatic pixel_req_t rand_req(input bit func, input bit fs);
    pixel_req_t q;
    q.func = func; q.fs = fs; q.u = rand_comp(); q.v = rand_comp();
    q.unk = ($urandom_range(0, 9) == 0);
    q.typed = 1'b0; q.rgb = '0;
    return q;
  endfunction

  // Receiver stall pattern: modes of free running, light and heavy stalling.
  int stall_mode = 0, stall_len = 0;
  always @(posedge clk_i) begin
    if (stall_len == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_len <= $urandom_range(20, 400);
    end else begin
      stall_len <= stall_len - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h%h%h", red, green, blue);
      end else begin
        if ({red, green, blue} !== pixel_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected %h actual %h%h%h", pixel_q[0], red, green, blue);
        end
        void'(pixel_q.pop_front());
      end
    end
  end

  pixel_req_t dir_tab [18] = '{
    '{1, 0, 16'd0,     16'd0,     0, 1, 24'hFFFFFF},
    '{1, 0, 16'd100,   16'd7,     1, 1, 24'h000000},
    '{1, 1, 16'h8000,  16'h7FFF,  1, 1, 24'h000000},
    '{0, 1, 16'h7FFF,  16'h7FFF,  1, 0, 24'h0},
    '{1, 0, 16'd64,    16'd0,     0, 0, 24'h0},
    '{0, 0, 16'h8000,  16'h8000,  0, 0, 24'h0},
    '{1, 0, 16'h8000,  16'h8000,  0, 0, 24'h0},
    '{1, 0, 16'h7FFF,  16'h7FFF,  0, 0, 24'h0},
    '{1, 0, 16'h7FFF,  16'h8000,  0, 0, 24'h0},
    '{1, 0, 16'd0,     16'd100,   0, 0, 24'h0},
    '{1, 0, -16'sd100, 16'd0,     0, 0, 24'h0},
    '{1, 0, 16'd0,     -16'sd100, 0, 0, 24'h0},
    '{1, 1, 16'd5,     16'd3,     0, 0, 24'h0},
    '{0, 1, 16'd3,     16'd4,     0, 0, 24'h0},
    '{1, 0, 16'd3,     16'd4,     0, 0, 24'h0},
    '{1, 0, 16'd6,     16'd8,     0, 0, 24'h0},
    '{1, 0, -16'sd3,   -16'sd4,   0, 0, 24'h0},
    '{1, 0, 16'hFFFF,  16'hFFFF,  1, 1, 24'h000000}
  };

  logic [15:0] radius_list [8] = '{16'd46341, 16'd0, 16'd1, 16'd64, 16'd0, 16'd700,
                                   16'd46341, 16'd0};

  initial begin
    int sent, nm, nc;
    for (int i = 0; i < 15; i++) begin
      colour_tab[i][0] = 255; colour_tab[i][1] = 255 * i / 15; colour_tab[i][2] = 0;
    end
    for (int i = 0; i < 6; i++) begin
      colour_tab[15+i][0] = 255 - 255 * i / 6; colour_tab[15+i][1] = 255;
      colour_tab[15+i][2] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      colour_tab[21+i][0] = 0; colour_tab[21+i][1] = 255; colour_tab[21+i][2] = 255 * i / 4;
    end
    for (int i = 0; i < 11; i++) begin
      colour_tab[25+i][0] = 0; colour_tab[25+i][1] = 255 - 255 * i / 11;
      colour_tab[25+i][2] = 255;
    end
    for (int i = 0; i < 13; i++) begin
      colour_tab[36+i][0] = 255 * i / 13; colour_tab[36+i][1] = 0; colour_tab[36+i][2] = 255;
    end
    for (int i = 0; i < 6; i++) begin
      colour_tab[49+i][0] = 255; colour_tab[49+i][1] = 0;
      colour_tab[49+i][2] = 255 - 255 * i / 6;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) send_req(dir_tab[i]);
    for (int ph = 0; ph < 8; ph++) begin
      write_radius(ph == 5 ? 16'($urandom_range(2, 46340)) : radius_list[ph]);
      sent = 0;
      while (sent < 200) begin
        if ($urandom_range(0, 9) < 7) begin
          // A well-formed frame: a measure pass then a colour pass.
          nm = $urandom_range(1, 12);
          nc = $urandom_range(1, 16);
          for (int i = 0; i < nm; i++) send_req(rand_req(1'b0, i == 0));
          for (int i = 0; i < nc; i++) send_req(rand_req(1'b1, $urandom_range(0, 1)));
          sent += nm + nc;
        end else begin
          send_req(rand_req($urandom_range(0, 1), $urandom_range(0, 1)));
          sent++;
        end
      end
    end
    drain();
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

>>> flow_vector_color_coder_unit.f
rtl/fvcc_pkg.sv
rtl/fvcc_front.sv
rtl/fvcc_back.sv
rtl/flow_vector_color_coder_unit.sv
rtl/fvcc_checker.sv
bench/flow_vector_color_coder_unit_tb.sv
